// ===== rtl/ltmm_pkg.sv =====
// ----------------------------------------------------------------------------
// ltmm_pkg
// shared types, constants and helper functions of the lower-triangular
// matrix multiply unit
// ----------------------------------------------------------------------------
`default_nettype none

package ltmm_pkg;

  localparam int MAX_ORDER_DEF = 16;

  localparam int ROW_W  = 4;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 5;
  localparam int TRI_W  = 8;   // holds r*(r+1)/2 + c for any 4-bit row and column

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // register index, taken from paddr[2]
  localparam logic REG_MATRIX_SIZE = 1'b0;

  localparam logic [1:0] FUNC_LOAD_B  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_C  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             saturated;
  } mac_result_t;

  function automatic int store_depth(input int order);
    return order * (order + 1) / 2;
  endfunction

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [TRI_W-1:0] tri_base(input logic [ROW_W-1:0] r);
    logic [TRI_W-1:0] rw;
    logic [TRI_W-1:0] prod;
    rw   = TRI_W'(r);
    prod = rw * (rw + TRI_W'(1));
    return prod >> 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lower_triangular_matmul_unit.sv =====
// ----------------------------------------------------------------------------
// lower_triangular_matmul_unit
// a = b * c for lower-triangular b and c of order up to MAX_ORDER
// ----------------------------------------------------------------------------
// Load transactions (func 0 for b, 1 for c) write one element in the cycle
// they are accepted; loads above the diagonal or at a row not below MAX_ORDER are dropped.
// A compute transaction (func 2) for row i emits row i of a, columns 0..i,
// with out_last on column i, or one out_error result when i is not below the
// order in use (min of matrix_size and MAX_ORDER). All products go through
// one shared 32x32 multiply-accumulate fed by one read port on each store, so
// element j issues its products k = j..i one after another, then drains the
// pipeline and hands the result off; out_stall holds the hand-off. The
// input channel is stalled for the whole compute transaction. Store contents
// are undefined after reset until written; matrix_size resets to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lower_triangular_matmul_unit
  import ltmm_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              func,
  input  wire logic [ROW_W-1:0]        row,
  input  wire logic [ROW_W-1:0]        col,
  input  wire logic signed [VAL_W-1:0] value,
  // output channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [ROW_W-1:0]             out_row,
  output logic [ROW_W-1:0]             out_col,
  output logic signed [VAL_W-1:0]      out_value,
  output logic                         out_last,
  output logic                         out_saturated,
  output logic                         out_error
);

  localparam int DEPTH = store_depth(MAX_ORDER);
  localparam int AW    = addr_bits(DEPTH);

  logic [SIZE_W-1:0] matrix_size;
  logic              cfg_write;

  logic              b_we;
  logic              c_we;
  logic [AW-1:0]     waddr;
  logic              re;
  logic [AW-1:0]     b_raddr;
  logic [AW-1:0]     c_raddr;
  logic [VAL_W-1:0]  b_data;
  logic [VAL_W-1:0]  c_data;
  logic [VAL_W-1:0]  res_value;
  mac_ctrl_t         mac_ctrl;
  mac_result_t       mac_result;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_write && paddr[2] == REG_MATRIX_SIZE) begin
      matrix_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MATRIX_SIZE) begin
      prdata = APB_DATA_W'(matrix_size);
    end
  end

  ltmm_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .matrix_size   (matrix_size),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .row           (row),
    .col           (col),
    .b_we          (b_we),
    .c_we          (c_we),
    .waddr         (waddr),
    .re            (re),
    .b_raddr       (b_raddr),
    .c_raddr       (c_raddr),
    .mac_ctrl      (mac_ctrl),
    .mac_result    (mac_result),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (res_value),
    .out_last      (out_last),
    .out_saturated (out_saturated),
    .out_error     (out_error)
  );

  assign out_value = res_value;

  ltmm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (value),
    .re    (re),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  ltmm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_c_store (
    .clk   (clk),
    .we    (c_we),
    .waddr (waddr),
    .wdata (value),
    .re    (re),
    .raddr (c_raddr),
    .rdata (c_data)
  );

  ltmm_mac #(
    .MAX_ORDER (MAX_ORDER)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .b_data (b_data),
    .c_data (c_data),
    .result (mac_result)
  );

endmodule

`default_nettype wire

// ===== rtl/ltmm_ram.sv =====
// ----------------------------------------------------------------------------
// ltmm_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ltmm_ram
  import ltmm_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 136
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [addr_bits(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic                          re,
  input  wire logic [addr_bits(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ltmm_mac.sv =====
// ----------------------------------------------------------------------------
// ltmm_mac
// shared multiply-accumulate unit: registered 32x32 product, exact wide
// accumulator, round to q16.16 and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module ltmm_mac
  import ltmm_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mac_ctrl_t               ctrl,
  input  wire logic signed [VAL_W-1:0] b_data,
  input  wire logic signed [VAL_W-1:0] c_data,
  output mac_result_t                  result
);

  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_ORDER);
  localparam int Q_W    = ACC_W - 16;

  logic                     issue_d;
  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic        [Q_W-1:0]    q;
  logic                     fits;

  // ram data arrives in the cycle after the read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_d    <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      issue_d    <= ctrl.issue;
      prod_valid <= issue_d;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_d) begin
      prod <= b_data * c_data;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // round half up at bit 15, then clip to 32 bits
  always_comb begin
    rnd  = acc + {{(ACC_W-16){1'b0}}, 1'b1, 15'b0};
    q    = rnd[ACC_W-1:16];
    fits = (&q[Q_W-1:VAL_W-1]) | ~(|q[Q_W-1:VAL_W-1]);
    result.saturated = ~fits;
    if (fits) begin
      result.value = q[VAL_W-1:0];
    end else if (q[Q_W-1]) begin
      result.value = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      result.value = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ltmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltmm_ctrl
// sequencer: input transactions, store writes, read address walk for each
// element of a row, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module ltmm_ctrl
  import ltmm_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic [SIZE_W-1:0]                       matrix_size,
  // input channel
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic [1:0]                              func,
  input  wire logic [ROW_W-1:0]                        row,
  input  wire logic [ROW_W-1:0]                        col,
  // stores
  output logic                                         b_we,
  output logic                                         c_we,
  output logic [addr_bits(store_depth(MAX_ORDER))-1:0] waddr,
  output logic                                         re,
  output logic [addr_bits(store_depth(MAX_ORDER))-1:0] b_raddr,
  output logic [addr_bits(store_depth(MAX_ORDER))-1:0] c_raddr,
  // shared mac
  output mac_ctrl_t                                    mac_ctrl,
  input  wire mac_result_t                             mac_result,
  // output channel
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [ROW_W-1:0]                             out_row,
  output logic [ROW_W-1:0]                             out_col,
  output logic [VAL_W-1:0]                             out_value,
  output logic                                         out_last,
  output logic                                         out_saturated,
  output logic                                         out_error
);

  localparam int AW = addr_bits(store_depth(MAX_ORDER));

  state_t           state;
  state_t           state_next;
  logic [ROW_W-1:0] i;
  logic [ROW_W-1:0] j;
  logic [ROW_W-1:0] k;
  logic [TRI_W-1:0] base_i;
  logic [TRI_W-1:0] tri_j;
  logic [TRI_W-1:0] b_addr;
  logic [TRI_W-1:0] c_addr;
  logic             err;
  logic             drain;

  logic             accept;
  logic             row_ok;
  logic             load_ok;
  logic             out_free;
  logic [TRI_W-1:0] load_addr;

  assign accept    = in_valid & ~in_stall;
  assign row_ok    = (int'(row) < int'(matrix_size)) && (int'(row) < MAX_ORDER);
  assign load_ok   = (int'(row) < MAX_ORDER) && (col <= row);
  assign out_free  = ~out_valid | ~out_stall;
  assign load_addr = tri_base(row) + TRI_W'(col);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_COMPUTE) begin
          state_next = row_ok ? ST_ISSUE : ST_EMIT;
        end
      end
      ST_ISSUE: begin
        if (k == i) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (err || j == i) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall       = 1'b1;
    re             = 1'b0;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.clear = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_ISSUE: begin
        re             = 1'b1;
        mac_ctrl.issue = 1'b1;
        mac_ctrl.clear = (k == j);
      end
      ST_DRAIN: in_stall = 1'b1;
      ST_EMIT:  in_stall = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  assign b_we    = accept && func == FUNC_LOAD_B && load_ok;
  assign c_we    = accept && func == FUNC_LOAD_C && load_ok;
  assign waddr   = AW'(load_addr);
  assign b_raddr = AW'(b_addr);
  assign c_raddr = AW'(c_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // address walk: b steps by one, c steps down a column by k+1
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          i      <= row;
          base_i <= tri_base(row);
          j      <= '0;
          k      <= '0;
          tri_j  <= '0;
          b_addr <= tri_base(row);
          c_addr <= '0;
          err    <= ~row_ok;
        end
      end
      ST_ISSUE: begin
        k      <= k + ROW_W'(1);
        b_addr <= b_addr + TRI_W'(1);
        c_addr <= c_addr + TRI_W'(k) + TRI_W'(1);
        drain  <= 1'b0;
      end
      ST_DRAIN: drain <= 1'b1;
      ST_EMIT: begin
        if (out_free) begin
          j      <= j + ROW_W'(1);
          k      <= j + ROW_W'(1);
          tri_j  <= tri_j + TRI_W'(j) + TRI_W'(1);
          b_addr <= base_i + TRI_W'(j) + TRI_W'(1);
          c_addr <= tri_j + TRI_W'(j) + TRI_W'(j) + TRI_W'(2);
        end
      end
      default: drain <= 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_row <= i;
      if (err) begin
        out_col       <= '0;
        out_value     <= '0;
        out_last      <= 1'b1;
        out_saturated <= 1'b0;
        out_error     <= 1'b1;
      end else begin
        out_col       <= j;
        out_value     <= mac_result.value;
        out_last      <= (j == i);
        out_saturated <= mac_result.saturated;
        out_error     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// random and directed check of the lower-triangular matrix multiply unit
// ----------------------------------------------------------------------------
// Element loads and row computes are queued by a stimulus process, driven with
// random gaps and taken back with random output stalls. Accepted transactions
// update a local copy of both stores, and every accepted compute is expanded
// into the row of a, or the error result, that it must produce. These are
// checked field by field as they come out. The order in use is rewritten
// between phases, including zero and values above the largest order.
// ----------------------------------------------------------------------------
module testbench;
  import ltmm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ORDER_MAX   = 16;
  localparam int TRI_SLOTS   = ORDER_MAX * (ORDER_MAX + 1) / 2;
  localparam int WAIT_MAX    = 13;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_SLACK = 8;

  typedef struct packed {
    logic [1:0]       func;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [VAL_W-1:0] value;
  } mm_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             saturated;
    logic             error;
  } a_elem_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  wire  [APB_DATA_W-1:0] prdata;
  wire                   pready;
  logic                  in_valid = 1'b0;
  wire                   in_stall;
  logic [1:0]            func = '0;
  logic [ROW_W-1:0]      row = '0;
  logic [ROW_W-1:0]      col = '0;
  logic [VAL_W-1:0]      value = '0;
  wire                   out_valid;
  logic                  out_stall = 1'b0;
  wire  [ROW_W-1:0]      out_row;
  wire  [ROW_W-1:0]      out_col;
  wire  [VAL_W-1:0]      out_value;
  wire                   out_last;
  wire                   out_saturated;
  wire                   out_error;

  lower_triangular_matmul_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .row(row), .col(col), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col), .out_value(out_value),
    .out_last(out_last), .out_saturated(out_saturated), .out_error(out_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // local copy of the block
  logic [VAL_W-1:0] b_mem [TRI_SLOTS];
  logic [VAL_W-1:0] c_mem [TRI_SLOTS];
  int unsigned      cfg_size = 16;
  a_elem_t          a_due[$];

  // stimulus side
  mm_cmd_t cmd_q[$];
  bit      b_known [TRI_SLOTS];
  bit      c_known [TRI_SLOTS];
  int      gen_order;
  bit      send_eager = 1'b0;
  bit      recv_eager = 1'b0;
  bit      hold_req = 1'b0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   fails = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_err = 0;
  int   n_sat = 0;

  function automatic int slot(input int r, input int c);
    return r * (r + 1) / 2 + c;
  endfunction

  function automatic a_elem_t a_entry(input int i, input int j);
    logic signed [71:0] acc;
    logic signed [71:0] q;
    a_elem_t            e;
    acc = '0;
    for (int k = j; k <= i; k++)
      acc = acc + $signed(b_mem[slot(i, k)]) * $signed(c_mem[slot(k, j)]);
    // round half up, then clip to q16.16
    q = (acc + 72'sd32768) >>> 16;
    e.row = ROW_W'(i);
    e.col = ROW_W'(j);
    e.last = (j == i);
    e.error = 1'b0;
    e.saturated = 1'b1;
    if (q > 72'sd2147483647) e.value = 32'h7fffffff;
    else if (q < -72'sd2147483648) e.value = 32'h80000000;
    else begin
      e.value = q[VAL_W-1:0];
      e.saturated = 1'b0;
    end
    return e;
  endfunction

  task automatic predict_cmd(input mm_cmd_t t);
    int      ord;
    a_elem_t e;
    ord = (cfg_size > ORDER_MAX) ? ORDER_MAX : int'(cfg_size);
    if ((t.func == FUNC_LOAD_B || t.func == FUNC_LOAD_C) && t.col <= t.row) begin
      if (t.func == FUNC_LOAD_B) b_mem[slot(t.row, t.col)] = t.value;
      else c_mem[slot(t.row, t.col)] = t.value;
    end else if (t.func == FUNC_COMPUTE) begin
      if (int'(t.row) >= ord) begin
        e.row = t.row;
        e.col = '0;
        e.value = '0;
        e.last = 1'b1;
        e.saturated = 1'b0;
        e.error = 1'b1;
        a_due.push_back(e);
      end else begin
        for (int j = 0; j <= int'(t.row); j++) a_due.push_back(a_entry(t.row, j));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      fails++;
      $error("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  // input acceptance, prediction and result checking
  always @(posedge clk) begin
    mm_cmd_t seen;
    a_elem_t want;
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        seen.func = func;
        seen.row = row;
        seen.col = col;
        seen.value = value;
        predict_cmd(seen);
        n_in++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (out_error) n_err++;
        if (out_saturated) n_sat++;
        if (a_due.size() == 0) begin
          fails++;
          $error("result transaction with nothing expected: row %0d col %0d", out_row, out_col);
        end else begin
          want = a_due.pop_front();
          check_field("out_row", 32'(want.row), 32'(out_row));
          check_field("out_col", 32'(want.col), 32'(out_col));
          check_field("out_value", want.value, out_value);
          check_field("out_last", 32'(want.last), 32'(out_last));
          check_field("out_saturated", 32'(want.saturated), 32'(out_saturated));
          check_field("out_error", 32'(want.error), 32'(out_error));
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    mm_cmd_t t;
    int      send_wait;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!in_valid || in_fire) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (cmd_q.size() > 0) begin
        t = cmd_q.pop_front();
        func <= t.func;
        row <= t.row;
        col <= t.col;
        value <= t.value;
        in_valid <= 1'b1;
        send_wait = send_eager ? 0 : $urandom_range(0, WAIT_MAX);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int recv_wait;
    int hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (out_fire) recv_wait = recv_eager ? 0 : $urandom_range(0, WAIT_MAX);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_matrix_size(input logic [SIZE_W-1:0] sz);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    word[SIZE_W-1:0] = sz;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MATRIX_SIZE, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_size = sz;
    gen_order = (sz > ORDER_MAX) ? ORDER_MAX : int'(sz);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (cmd_q.size() > 0 || in_valid || a_due.size() > 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000000;
          default: return 32'h00010000;
        endcase
      end
      1, 2: return $urandom();
      default: return 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
    endcase
    return '0;
  endfunction

  task automatic queue_cmd(input logic [1:0] f, input int r, input int c,
                           input logic [VAL_W-1:0] v);
    mm_cmd_t t;
    t.func = f;
    t.row = ROW_W'(r);
    t.col = ROW_W'(c);
    t.value = v;
    cmd_q.push_back(t);
    if (c <= r && f == FUNC_LOAD_B) b_known[slot(r, c)] = 1'b1;
    if (c <= r && f == FUNC_LOAD_C) c_known[slot(r, c)] = 1'b1;
  endtask

  // a valid row reads b row r and c rows 0..r, so fill any unwritten entry first
  task automatic queue_row(input int r);
    if (r < gen_order) begin
      for (int k = 0; k <= r; k++)
        if (!b_known[slot(r, k)]) queue_cmd(FUNC_LOAD_B, r, k, rand_q16());
      for (int m = 0; m <= r; m++)
        for (int k = 0; k <= m; k++)
          if (!c_known[slot(m, k)]) queue_cmd(FUNC_LOAD_C, m, k, rand_q16());
    end
    queue_cmd(FUNC_COMPUTE, r, $urandom_range(0, 15), $urandom());
  endtask

  task automatic queue_random(input int count);
    int pick;
    int r;
    int c;
    int bias;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 15);
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, r);
      if (pick < 30) queue_cmd(FUNC_LOAD_B, r, c, rand_q16());
      else if (pick < 55) queue_cmd(FUNC_LOAD_C, r, c, rand_q16());
      else if (pick < 93) begin
        bias = $urandom_range(0, 9);
        // mostly short rows, some up to the order in use, a few anywhere
        if (gen_order > 0 && bias < 5)
          r = $urandom_range(0, (gen_order > 5) ? 4 : gen_order - 1);
        else if (gen_order > 0 && bias < 8)
          r = $urandom_range(0, gen_order - 1);
        queue_row(r);
      end else begin
        queue_cmd(FUNC_UNUSED, r, c, $urandom());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // saturation both ways, rounding ties and dropped loads
    write_matrix_size(5'd16);
    queue_cmd(FUNC_LOAD_B, 0, 0, 32'h7fffffff);
    queue_cmd(FUNC_LOAD_C, 0, 0, 32'h7fffffff);
    queue_cmd(FUNC_COMPUTE, 0, 0, '0);
    queue_cmd(FUNC_LOAD_B, 0, 0, 32'h80000000);
    queue_cmd(FUNC_COMPUTE, 0, 15, 32'hffffffff);
    queue_cmd(FUNC_LOAD_C, 0, 0, 32'h80000000);
    queue_cmd(FUNC_COMPUTE, 0, 0, '0);
    queue_cmd(FUNC_LOAD_B, 0, 0, 32'h00000001);
    queue_cmd(FUNC_LOAD_C, 0, 0, 32'h00008000);
    queue_cmd(FUNC_COMPUTE, 0, 0, '0);
    queue_cmd(FUNC_LOAD_B, 0, 0, 32'hffffffff);
    queue_cmd(FUNC_COMPUTE, 0, 0, '0);
    queue_cmd(FUNC_LOAD_B, 1, 15, 32'hffffffff);
    queue_cmd(FUNC_LOAD_C, 0, 15, 32'hffffffff);
    queue_cmd(FUNC_UNUSED, 15, 15, 32'hffffffff);
    queue_row(2);
    wait_drained();

    // order one: rows past it are errors
    write_matrix_size(5'd1);
    queue_cmd(FUNC_COMPUTE, 1, 0, '0);
    queue_cmd(FUNC_COMPUTE, 15, 15, 32'hffffffff);
    queue_row(0);
    queue_random(10);
    wait_drained();

    // order zero, no idling on either side
    send_eager = 1'b1;
    recv_eager = 1'b1;
    write_matrix_size(5'd0);
    queue_random(10);
    wait_drained();

    // above the largest order; output held off while input keeps coming
    send_eager = 1'b0;
    recv_eager = 1'b0;
    write_matrix_size(5'd31);
    queue_random(30);
    hold_req = 1'b1;
    wait_drained();

    send_eager = ($urandom_range(0, 2) == 0);
    recv_eager = ($urandom_range(0, 2) == 0);
    write_matrix_size(5'($urandom_range(2, 15)));
    queue_random(25);
    wait_drained();

    // full order, sender pausing midway until the block is empty
    send_eager = 1'b0;
    recv_eager = ($urandom_range(0, 1) == 0);
    write_matrix_size(5'd16);
    queue_random(15);
    wait_drained();
    queue_random(15);
    wait_drained();

    $display("%0d input transactions, %0d result transactions checked", n_in, n_out);
    $display("orders 0, 1, 16 and above 16 exercised; %0d error and %0d saturated results",
             n_err, n_sat);
    if (fails == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ltmm_pkg.sv
rtl/ltmm_ram.sv
rtl/ltmm_mac.sv
rtl/ltmm_ctrl.sv
rtl/lower_triangular_matmul_unit.sv
tb/testbench.sv
